[rtl/core/slsup_pkg.sv]
// ----------------------------------------------------------------------------
// slsup_pkg
// Types, constants and the bar quantizer shared by the link supervisor.
// ----------------------------------------------------------------------------
package slsup_pkg;

  typedef enum logic [2:0] {
    MODE_START     = 3'd0,
    MODE_STOP      = 3'd1,
    MODE_RADIO_UP  = 3'd2,
    MODE_DISCONN   = 3'd3,
    MODE_GOT_ADDR  = 3'd4,
    MODE_LOW_ALARM = 3'd5,
    MODE_SAMPLE    = 3'd6
  } mode_e;

  // Configuration register indexes.
  localparam logic CFG_MAX_RETRY = 1'b0;
  localparam logic CFG_WEAK_DBM  = 1'b1;

  localparam logic [7:0]        MAX_RETRY_RST = 8'd5;
  localparam logic signed [7:0] WEAK_DBM_RST  = -8'sd75;

  localparam int                NUM_BARS = 4;
  localparam logic signed [8:0] HYST_DB  = 9'sd3;
  localparam logic signed [8:0] BAR_FLOORS [NUM_BARS] = '{
    -9'sd85, -9'sd75, -9'sd67, -9'sd55
  };

  typedef struct packed {
    logic [3:0]        channel;
    logic              associated;
    logic signed [7:0] rssi;
    logic [2:0]        mode;
  } item_t;

  typedef struct packed {
    logic [3:0]        channel_out;
    logic signed [7:0] rssi_out;
    logic              weak_res;
    logic [2:0]        bars;
    logic              signal_valid;
    logic              weak_log_line;
    logic              arm_weak_alarm;
    logic              link_failed;
    logic              link_up;
    logic [7:0]        retry_count;
    logic              connect_attempt;
  } result_t;

  // Bars with hysteresis: a bar above the previous level needs 3 dB of margin.
  function automatic logic [2:0] quantize(logic signed [7:0] rssi, logic [2:0] prev);
    logic signed [8:0] level;
    logic signed [8:0] flr;
    logic [2:0]        bars;
    logic              found;
    level = {rssi[7], rssi};
    bars  = 3'd0;
    found = 1'b0;
    for (int i = NUM_BARS - 1; i >= 0; i--) begin
      flr = BAR_FLOORS[i];
      if (3'(i + 1) > prev) begin
        flr = flr + HYST_DB;
      end
      if (!found && (level >= flr)) begin
        bars  = 3'(i + 1);
        found = 1'b1;
      end
    end
    return bars;
  endfunction

endpackage

[rtl/core/station_link_supervisor.sv]
// Throughput: one event per cycle while the downstream side takes results;
// the link state is updated as each event moves from the input register
// into the result register, where its result word is held.
// Reset (rst_ni low, asynchronous) empties both registers, clears the link
// state and returns max_retry to 5 and the weak threshold to -75 dBm.
// ----------------------------------------------------------------------------
// station_link_supervisor
// Radio link supervisor: connection retries, failure flag and signal bars.
// ----------------------------------------------------------------------------
module station_link_supervisor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rssi[7:0], associated[8], channel[12:9], zero[15:13]
  input  logic [15:0] s_axis_tdata,
  // mode[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // connect_attempt[0], retry_count[8:1], link_up[9], link_failed[10],
  // arm_weak_alarm[11], weak_log_line[12], signal_valid[13], bars[16:14],
  // weak_res[17], rssi_out[25:18], channel_out[29:26], zero[31:30]
  output logic [31:0] m_axis_tdata
);
  import slsup_pkg::*;

  item_t   in_item, reg_item;
  result_t eng_result, out_result;
  logic    reg_valid, out_ready, advance;

  assign in_item.mode       = s_axis_tuser;
  assign in_item.rssi       = s_axis_tdata[7:0];
  assign in_item.associated = s_axis_tdata[8];
  assign in_item.channel    = s_axis_tdata[12:9];

  assign advance = reg_valid && out_ready;

  slsup_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (reg_valid),
    .take_i  (advance),
    .item_o  (reg_item)
  );

  slsup_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (reg_item),
    .commit_i    (advance),
    .result_o    (eng_result)
  );

  slsup_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .ready_o  (out_ready),
    .result_i (eng_result),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {2'b00, out_result};

endmodule

[rtl/core/slsup_in_reg.sv]
// ----------------------------------------------------------------------------
// slsup_in_reg
// Input register: holds one event word until the engine consumes it.
// ----------------------------------------------------------------------------
module slsup_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  slsup_pkg::item_t     item_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output slsup_pkg::item_t     item_o
);
  import slsup_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/slsup_engine.sv]
// ----------------------------------------------------------------------------
// slsup_engine
// Link state, configuration registers and per-event result logic.
// ----------------------------------------------------------------------------
module slsup_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [7:0]           cfg_wdata_i,
  input  slsup_pkg::item_t     item_i,
  input  logic                 commit_i,
  output slsup_pkg::result_t   result_o
);
  import slsup_pkg::*;

  logic [7:0]        max_retry_q;
  logic signed [7:0] weak_dbm_q;

  logic       connecting_q, connecting_d;
  logic [7:0] retries_q, retries_d;
  logic       connected_q, connected_d;
  logic       failed_q, failed_d;
  logic [2:0] last_bars_q, last_bars_d;
  logic       weak_rep_q, weak_rep_d;

  logic [2:0]        new_bars;
  logic signed [8:0] weak_limit;
  result_t           res;

  assign new_bars   = quantize(item_i.rssi, last_bars_q);
  assign weak_limit = {weak_dbm_q[7], weak_dbm_q} + HYST_DB;

  always_comb begin
    connecting_d = connecting_q;
    retries_d    = retries_q;
    connected_d  = connected_q;
    failed_d     = failed_q;
    last_bars_d  = last_bars_q;
    weak_rep_d   = weak_rep_q;
    res          = '0;
    unique case (item_i.mode)
      MODE_START: begin
        failed_d     = 1'b0;
        connected_d  = 1'b0;
        retries_d    = '0;
        connecting_d = 1'b1;
      end
      MODE_STOP: begin
        connecting_d = 1'b0;
        retries_d    = '0;
        last_bars_d  = '0;
        weak_rep_d   = 1'b0;
        connected_d  = 1'b0;
        failed_d     = 1'b0;
      end
      MODE_RADIO_UP: begin
        res.connect_attempt = connecting_q;
      end
      MODE_DISCONN: begin
        if (connecting_q) begin
          if (retries_q < max_retry_q) begin
            retries_d           = retries_q + 8'd1;
            res.connect_attempt = 1'b1;
          end else begin
            failed_d = 1'b1;
          end
        end
      end
      MODE_GOT_ADDR: begin
        retries_d          = '0;
        res.arm_weak_alarm = 1'b1;
        connected_d        = 1'b1;
      end
      MODE_LOW_ALARM: begin
        if (!weak_rep_q) begin
          weak_rep_d        = 1'b1;
          res.weak_log_line = 1'b1;
        end
        res.arm_weak_alarm = 1'b1;
      end
      MODE_SAMPLE: begin
        if (!item_i.associated) begin
          last_bars_d = '0;
        end else begin
          last_bars_d = new_bars;
          if ($signed({item_i.rssi[7], item_i.rssi}) >= weak_limit) begin
            weak_rep_d = 1'b0;
          end
          res.signal_valid = 1'b1;
          res.bars         = new_bars;
          res.weak_res     = (new_bars <= 3'd1);
          res.rssi_out     = item_i.rssi;
          res.channel_out  = item_i.channel;
        end
      end
      default: begin
      end
    endcase
    res.retry_count = retries_d;
    res.link_up     = connected_d;
    res.link_failed = failed_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retry_q <= MAX_RETRY_RST;
      weak_dbm_q  <= WEAK_DBM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MAX_RETRY: max_retry_q <= cfg_wdata_i;
        CFG_WEAK_DBM:  weak_dbm_q  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connecting_q <= 1'b0;
      retries_q    <= '0;
      connected_q  <= 1'b0;
      failed_q     <= 1'b0;
      last_bars_q  <= '0;
      weak_rep_q   <= 1'b0;
    end else if (commit_i) begin
      connecting_q <= connecting_d;
      retries_q    <= retries_d;
      connected_q  <= connected_d;
      failed_q     <= failed_d;
      last_bars_q  <= last_bars_d;
      weak_rep_q   <= weak_rep_d;
    end
  end

endmodule

[rtl/core/slsup_out_reg.sv]
// ----------------------------------------------------------------------------
// slsup_out_reg
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module slsup_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  output logic                 ready_o,
  input  slsup_pkg::result_t   result_i,
  output logic                 valid_o,
  input  logic                 take_i,
  output slsup_pkg::result_t   result_o
);
  import slsup_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // A held word that is being taken frees the register in the same cycle.
  assign ready_o = !valid_q || take_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
